[hdl/tl_pkg.sv]
package tl_pkg;

    localparam int MAX_TOKEN = 255;
    localparam int LEN_W     = $clog2(MAX_TOKEN + 1);

    localparam int RQ_DEPTH = 4;
    localparam int RQ_AW    = $clog2(RQ_DEPTH);
    localparam int RQ_CW    = $clog2(RQ_DEPTH + 1);

    localparam logic [3:0] KIND_MAIN    = 4'd0;
    localparam logic [3:0] KIND_PRINT   = 4'd1;
    localparam logic [3:0] KIND_STRING  = 4'd2;
    localparam logic [3:0] KIND_IDENT   = 4'd3;
    localparam logic [3:0] KIND_LPAREN  = 4'd4;
    localparam logic [3:0] KIND_RPAREN  = 4'd5;
    localparam logic [3:0] KIND_LBRACE  = 4'd6;
    localparam logic [3:0] KIND_RBRACE  = 4'd7;
    localparam logic [3:0] KIND_END     = 4'd8;
    localparam logic [3:0] KIND_RETURN  = 4'd9;
    localparam logic [3:0] KIND_UNKNOWN = 4'd10;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    localparam logic [7:0] KW_TEXT [3][8] = '{
        '{8'h6D, 8'h61, 8'h69, 8'h6E, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h70, 8'h72, 8'h69, 8'h6E, 8'h74, 8'h00, 8'h00, 8'h00},
        '{8'h72, 8'h65, 8'h74, 8'h75, 8'h72, 8'h6E, 8'h00, 8'h00}
    };
    localparam int         KW_LEN  [3] = '{4, 5, 6};
    localparam logic [3:0] KW_KIND [3] = '{KIND_MAIN, KIND_PRINT, KIND_RETURN};

    typedef enum logic [3:0] {
        MODE_IDLE   = 4'b0001,
        MODE_STRING = 4'b0010,
        MODE_WORD   = 4'b0100,
        MODE_DIGITS = 4'b1000
    } t_mode;

    typedef struct packed {
        logic [3:0] kind;
        logic       is_char;
        logic [7:0] value_char;
        logic [7:0] token_length;
        logic       last;
    } t_result;

    typedef struct packed {
        logic [1:0] cnt;
        t_result    r0;
        t_result    r1;
    } t_push;

    function automatic t_result mk_token(logic [3:0] kind);
        t_result r;
        r = '0;
        r.kind = kind;
        return r;
    endfunction

    function automatic t_result mk_char(logic [3:0] kind, logic [7:0] c);
        t_result r;
        r = '0;
        r.kind       = kind;
        r.is_char    = 1'b1;
        r.value_char = c;
        return r;
    endfunction

    function automatic t_result mk_close(logic [3:0] kind, logic [LEN_W-1:0] len);
        t_result r;
        r = '0;
        r.kind         = kind;
        r.token_length = (32'(len) > 32'd255) ? 8'hFF : 8'(len);
        return r;
    endfunction

    function automatic logic [2:0] kw_filter(logic [2:0] cand, logic [LEN_W-1:0] pos,
                                             logic [7:0] c);
        logic [2:0] keep;
        keep = '0;
        for (int k = 0; k < 3; k++) begin
            keep[k] = cand[k] && (32'(pos) < KW_LEN[k]) && (KW_TEXT[k][pos[2:0]] == c);
        end
        return keep;
    endfunction

    function automatic logic [3:0] word_kind(logic [2:0] cand, logic [LEN_W-1:0] len);
        logic [3:0] kind;
        kind = KIND_IDENT;
        for (int k = 2; k >= 0; k--) begin
            if (cand[k] && (32'(len) == KW_LEN[k])) begin
                kind = KW_KIND[k];
            end
        end
        return kind;
    endfunction

endpackage

[hdl/tl_scan.sv]
module tl_scan (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [7:0]    i_ch,
    input  logic          i_is_end,
    input  logic          i_room,
    output tl_pkg::t_push o_push
);
    import tl_pkg::*;

    logic             r_in_valid;
    logic [7:0]       r_ch;
    logic             r_end;
    t_mode            r_mode;
    logic [LEN_W-1:0] r_len;
    logic [2:0]       r_cand;

    t_mode            n_mode;
    logic [LEN_W-1:0] n_len;
    logic [2:0]       n_cand;

    logic             take;
    logic             is_ws;
    logic             is_letter;
    logic             is_digit;
    logic             has_room;

    logic             id_has;
    t_result          id_res;
    t_mode            id_mode;
    logic [LEN_W-1:0] id_len;
    logic [2:0]       id_cand;

    logic             do_idle;
    logic [1:0]       cnt;
    t_result          r0;
    t_result          r1;

    assign take    = r_in_valid && i_room;
    assign o_ready = !r_in_valid || take;

    assign is_ws     = (r_ch == 8'd32) || ((r_ch >= 8'd9) && (r_ch <= 8'd13));
    assign is_letter = ((r_ch >= 8'h61) && (r_ch <= 8'h7A)) ||
                       ((r_ch >= 8'h41) && (r_ch <= 8'h5A));
    assign is_digit  = (r_ch >= 8'h30) && (r_ch <= 8'h39);
    assign has_room  = r_len < LEN_W'(MAX_TOKEN);

    always_comb begin
        id_has  = 1'b0;
        id_res  = mk_token(KIND_UNKNOWN);
        id_mode = MODE_IDLE;
        id_len  = '0;
        id_cand = 3'b111;
        if (r_end) begin
            id_has = 1'b1;
            id_res = mk_token(KIND_END);
        end else if (is_ws) begin
            id_has = 1'b0;
        end else if (r_ch == CH_LPAREN) begin
            id_has = 1'b1;
            id_res = mk_token(KIND_LPAREN);
        end else if (r_ch == CH_RPAREN) begin
            id_has = 1'b1;
            id_res = mk_token(KIND_RPAREN);
        end else if (r_ch == CH_LBRACE) begin
            id_has = 1'b1;
            id_res = mk_token(KIND_LBRACE);
        end else if (r_ch == CH_RBRACE) begin
            id_has = 1'b1;
            id_res = mk_token(KIND_RBRACE);
        end else if (r_ch == CH_QUOTE) begin
            id_mode = MODE_STRING;
        end else if (is_letter) begin
            id_has  = 1'b1;
            id_res  = mk_char(KIND_IDENT, r_ch);
            id_mode = MODE_WORD;
            id_len  = LEN_W'(1);
            id_cand = kw_filter(3'b111, '0, r_ch);
        end else if (is_digit) begin
            id_has  = 1'b1;
            id_res  = mk_char(KIND_IDENT, r_ch);
            id_mode = MODE_DIGITS;
            id_len  = LEN_W'(1);
        end else begin
            id_has = 1'b1;
        end
    end

    always_comb begin
        n_mode  = r_mode;
        n_len   = r_len;
        n_cand  = r_cand;
        do_idle = 1'b0;
        cnt     = 2'd0;
        r0      = '0;
        r1      = '0;
        unique case (r_mode)
            MODE_STRING: begin
                if (r_end || (r_ch == CH_QUOTE)) begin
                    r0     = mk_close(KIND_STRING, r_len);
                    cnt    = 2'd1;
                    n_mode = MODE_IDLE;
                    n_len  = '0;
                    if (r_end) begin
                        r1  = mk_token(KIND_END);
                        cnt = 2'd2;
                    end
                end else if (has_room) begin
                    r0    = mk_char(KIND_STRING, r_ch);
                    cnt   = 2'd1;
                    n_len = r_len + LEN_W'(1);
                end
            end
            MODE_WORD: begin
                if (!r_end && (is_letter || is_digit)) begin
                    n_cand = kw_filter(r_cand, r_len, r_ch);
                    if (has_room) begin
                        r0    = mk_char(KIND_IDENT, r_ch);
                        cnt   = 2'd1;
                        n_len = r_len + LEN_W'(1);
                    end
                end else begin
                    r0      = mk_close(word_kind(r_cand, r_len), r_len);
                    cnt     = 2'd1;
                    do_idle = 1'b1;
                end
            end
            MODE_DIGITS: begin
                if (!r_end && is_digit) begin
                    if (has_room) begin
                        r0    = mk_char(KIND_IDENT, r_ch);
                        cnt   = 2'd1;
                        n_len = r_len + LEN_W'(1);
                    end
                end else begin
                    r0      = mk_close(KIND_IDENT, r_len);
                    cnt     = 2'd1;
                    do_idle = 1'b1;
                end
            end
            default: begin
                do_idle = 1'b1;
            end
        endcase
        if (do_idle) begin
            n_mode = id_mode;
            n_len  = id_len;
            n_cand = id_cand;
            if (id_has) begin
                if (cnt == 2'd0) begin
                    r0  = id_res;
                    cnt = 2'd1;
                end else begin
                    r1  = id_res;
                    cnt = 2'd2;
                end
            end
        end
        if (cnt == 2'd1) begin
            r0.last = 1'b1;
        end
        if (cnt == 2'd2) begin
            r1.last = 1'b1;
        end
    end

    assign o_push.cnt = take ? cnt : 2'd0;
    assign o_push.r0  = r0;
    assign o_push.r1  = r1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_mode     <= MODE_IDLE;
            r_len      <= '0;
            r_cand     <= 3'b111;
        end else begin
            if (i_valid && o_ready) begin
                r_in_valid <= 1'b1;
            end else if (take) begin
                r_in_valid <= 1'b0;
            end
            if (take) begin
                r_mode <= n_mode;
                r_len  <= n_len;
                r_cand <= n_cand;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_ch  <= i_ch;
            r_end <= i_is_end;
        end
    end

endmodule

[hdl/tl_rq.sv]
module tl_rq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  tl_pkg::t_push   i_push,
    output logic            o_room,
    output logic            o_valid,
    input  logic            i_ready,
    output tl_pkg::t_result o_head
);
    import tl_pkg::*;

    t_result          r_mem [RQ_DEPTH];
    logic [RQ_AW-1:0] r_wp;
    logic [RQ_AW-1:0] r_rp;
    logic [RQ_CW-1:0] r_cnt;
    logic             pop;

    assign o_valid = r_cnt != '0;
    assign o_room  = r_cnt <= RQ_CW'(RQ_DEPTH - 2);
    assign pop     = o_valid && i_ready;
    assign o_head  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wp] <= i_push.r0;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[r_wp + RQ_AW'(1)] <= i_push.r1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + RQ_AW'(i_push.cnt);
            r_rp  <= r_rp + RQ_AW'(pop);
            r_cnt <= r_cnt + RQ_CW'(i_push.cnt) - RQ_CW'(pop);
        end
    end

endmodule

[hdl/token_lexer.sv]
// Streaming lexer: one source character per request on the input channel,
// tokens out on the result channel. Both channels use valid/ready.
// The input request carries i_ch and i_is_end; i_is_end closes any open
// token and then yields an end token. Each request gives zero, one or two
// results; o_last marks the final result caused by that request. Value
// characters of strings, words and digit runs stream out one per result
// with o_is_char set; the closing result carries the kind and length.
// A request is registered in the scanner, scanned combinationally, and its
// results are written into the result queue once it has room. Throughput:
// one request per cycle while each gives at most one result and results
// are taken; requests that give two results can hold the input back. The
// limit is the four-entry result queue, drained one result per cycle while
// i_out_ready is high. When the receiver stalls, the queue fills and
// o_in_ready drops once fewer than two queue entries are free. Reset empties
// the queue, drops any held request and returns the scanner to idle.
module token_lexer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_ch,
    input  logic       i_is_end,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [3:0] o_kind,
    output logic       o_is_char,
    output logic [7:0] o_value_char,
    output logic [7:0] o_token_length,
    output logic       o_last
);
    import tl_pkg::*;

    t_push   push;
    t_result head;
    logic    room;

    tl_scan u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in_valid),
        .o_ready  (o_in_ready),
        .i_ch     (i_ch),
        .i_is_end (i_is_end),
        .i_room   (room),
        .o_push   (push)
    );

    tl_rq u_rq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_head  (head)
    );

    assign o_kind         = head.kind;
    assign o_is_char      = head.is_char;
    assign o_value_char   = head.value_char;
    assign o_token_length = head.token_length;
    assign o_last         = head.last;

endmodule

[hdl/tl_checker.sv]
module tl_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [3:0] o_kind,
    input logic       o_is_char,
    input logic [7:0] o_value_char,
    input logic [7:0] o_token_length,
    input logic       o_last
);
    import tl_pkg::*;

    a_reset_empty : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_out_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_kind) &&
        $stable(o_is_char) && $stable(o_value_char) && $stable(o_token_length) &&
        $stable(o_last))
        else $error("stalled result changed");

    a_char_fields : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_is_char |-> o_token_length == 8'd0 && !o_last == 1'b0 &&
        (o_kind == KIND_STRING || o_kind == KIND_IDENT))
        else $error("character result with bad kind, length or last");

    a_close_fields : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_is_char |-> o_value_char == 8'd0)
        else $error("token result carries a value character");

    a_end_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == KIND_END |-> o_last)
        else $error("end token not marked last");

endmodule

bind token_lexer tl_checker u_tl_checker (.*);

[sim/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
    import tl_pkg::*;

    localparam int         RANDOM_ITEMS = 1400;
    localparam int         HOLD_CYCLES  = 300;
    localparam int         QUIET_LIMIT  = 4000;
    localparam int         DRAIN_CYCLES = 10;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_SPACE     = 8'h20;

    class token_scoreboard;
        t_mode      scan;
        int         held;
        logic [2:0] maybe_kw;
        t_result    expected_tokens[$];
        int         errors;
        string      kw_word[3];
        logic [3:0] kw_code[3];

        function new();
            kw_word  = '{"main", "print", "return"};
            kw_code  = '{KIND_MAIN, KIND_PRINT, KIND_RETURN};
            scan     = MODE_IDLE;
            held     = 0;
            maybe_kw = '1;
            errors   = 0;
        endfunction

        function bit is_space(logic [7:0] c);
            return c == CH_SPACE || (c >= CH_TAB && c <= CH_TAB + 8'd4);
        endfunction

        function bit is_alpha(logic [7:0] c);
            return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
        endfunction

        function bit is_num(logic [7:0] c);
            return c >= "0" && c <= "9";
        endfunction

        function void push_token(logic [3:0] kind, logic is_char, logic [7:0] c, int len);
            t_result r;
            r              = '0;
            r.kind         = kind;
            r.is_char      = is_char;
            r.value_char   = c;
            r.token_length = (len > 255) ? 8'hFF : 8'(len);
            expected_tokens.push_back(r);
        endfunction

        // Characters past the length cap are dropped without a result.
        function void keep_char(logic [7:0] c, logic [3:0] kind);
            if (held < MAX_TOKEN) begin
                held++;
                push_token(kind, 1'b1, c, 0);
            end
        endfunction

        function void narrow_keywords(int pos, logic [7:0] c);
            for (int k = 0; k < 3; k++) begin
                if (maybe_kw[k] && (pos >= kw_word[k].len() || kw_word[k][pos] != c)) begin
                    maybe_kw[k] = 1'b0;
                end
            end
        endfunction

        function logic [3:0] closed_word_kind();
            for (int k = 0; k < 3; k++) begin
                if (maybe_kw[k] && held == kw_word[k].len()) begin
                    return kw_code[k];
                end
            end
            return KIND_IDENT;
        endfunction

        function void start_from_idle(logic [7:0] c, logic e);
            if (e) begin
                push_token(KIND_END, 1'b0, 8'h00, 0);
            end else if (is_space(c)) begin
                return;
            end else if (c == CH_LPAREN) begin
                push_token(KIND_LPAREN, 1'b0, 8'h00, 0);
            end else if (c == CH_RPAREN) begin
                push_token(KIND_RPAREN, 1'b0, 8'h00, 0);
            end else if (c == CH_LBRACE) begin
                push_token(KIND_LBRACE, 1'b0, 8'h00, 0);
            end else if (c == CH_RBRACE) begin
                push_token(KIND_RBRACE, 1'b0, 8'h00, 0);
            end else if (c == CH_QUOTE) begin
                scan = MODE_STRING;
                held = 0;
            end else if (is_alpha(c)) begin
                scan     = MODE_WORD;
                held     = 0;
                maybe_kw = '1;
                narrow_keywords(0, c);
                keep_char(c, KIND_IDENT);
            end else if (is_num(c)) begin
                scan = MODE_DIGITS;
                held = 0;
                keep_char(c, KIND_IDENT);
            end else begin
                push_token(KIND_UNKNOWN, 1'b0, 8'h00, 0);
            end
        endfunction

        function void note_char(logic [7:0] c, logic e);
            int      n_old;
            t_result r;
            n_old = expected_tokens.size();
            case (scan)
                MODE_STRING: begin
                    if (e || c == CH_QUOTE) begin
                        push_token(KIND_STRING, 1'b0, 8'h00, held);
                        scan = MODE_IDLE;
                        held = 0;
                        if (e) begin
                            push_token(KIND_END, 1'b0, 8'h00, 0);
                        end
                    end else begin
                        keep_char(c, KIND_STRING);
                    end
                end
                MODE_WORD: begin
                    if (!e && (is_alpha(c) || is_num(c))) begin
                        narrow_keywords(held, c);
                        keep_char(c, KIND_IDENT);
                    end else begin
                        push_token(closed_word_kind(), 1'b0, 8'h00, held);
                        scan     = MODE_IDLE;
                        held     = 0;
                        maybe_kw = '1;
                        start_from_idle(c, e);
                    end
                end
                MODE_DIGITS: begin
                    if (!e && is_num(c)) begin
                        keep_char(c, KIND_IDENT);
                    end else begin
                        push_token(KIND_IDENT, 1'b0, 8'h00, held);
                        scan = MODE_IDLE;
                        held = 0;
                        start_from_idle(c, e);
                    end
                end
                default: begin
                    scan = MODE_IDLE;
                    start_from_idle(c, e);
                end
            endcase
            if (expected_tokens.size() > n_old) begin
                r      = expected_tokens.pop_back();
                r.last = 1'b1;
                expected_tokens.push_back(r);
            end
        endfunction

        function void check_token(t_result got);
            t_result want;
            if (expected_tokens.size() == 0) begin
                if (errors < 10) begin
                    $display("unexpected token: kind %0d is_char %0b char %02h len %0d last %0b",
                             got.kind, got.is_char, got.value_char, got.token_length, got.last);
                end
                errors++;
                return;
            end
            want = expected_tokens.pop_front();
            if (got !== want) begin
                if (errors < 10) begin
                    $display("token mismatch: expected kind %0d is_char %0b char %02h len %0d last %0b",
                             want.kind, want.is_char, want.value_char, want.token_length,
                             want.last);
                    $display("                got      kind %0d is_char %0b char %02h len %0d last %0b",
                             got.kind, got.is_char, got.value_char, got.token_length, got.last);
                end
                errors++;
            end
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic [7:0] in_ch = 8'h00;
    logic       in_end = 1'b0;
    logic       out_ready = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic [3:0] o_kind;
    logic       o_is_char;
    logic [7:0] o_value_char;
    logic [7:0] o_token_length;
    logic       o_last;

    token_scoreboard sb = new();
    int  sent_chars   = 0;
    int  quiet_cycles = 0;
    bit  steady       = 1'b0;
    bit  hold_go      = 1'b0;

    token_lexer u_top (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (o_in_ready),
        .i_ch           (in_ch),
        .i_is_end       (in_end),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (out_ready),
        .o_kind         (o_kind),
        .o_is_char      (o_is_char),
        .o_value_char   (o_value_char),
        .o_token_length (o_token_length),
        .o_last         (o_last)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end else if (r < 98) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [7:0] rand_alpha();
        int r;
        r = $urandom_range(0, 51);
        return (r < 26) ? 8'("a" + r) : 8'("A" + r - 26);
    endfunction

    function automatic logic [7:0] rand_alnum();
        int r;
        r = $urandom_range(0, 61);
        return (r < 52) ? rand_alpha() : 8'("0" + r - 52);
    endfunction

    function automatic logic [7:0] rand_space();
        int r;
        r = $urandom_range(0, 5);
        return (r == 5) ? CH_SPACE : 8'(CH_TAB + r);
    endfunction

    function automatic logic [7:0] rand_not_quote();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255)); while (c == CH_QUOTE);
        return c;
    endfunction

    task automatic send_char(input logic [7:0] c, input logic e);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_ch    <= c;
        in_end   <= e;
        do @(posedge clk); while (!o_in_ready);
        sb.note_char(c, e);
        sent_chars++;
        @(negedge clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_char(s[i], 1'b0);
        end
    endtask

    task automatic send_end();
        send_char(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic send_lexeme();
        int    r;
        int    n;
        string kw;
        r = $urandom_range(0, 99);
        if (r < 15) begin
            case ($urandom_range(0, 2))
                0:       kw = "main";
                1:       kw = "print";
                default: kw = "return";
            endcase
            n = $urandom_range(0, 3);
            if (n == 2) begin
                kw = kw.substr(0, kw.len() - 2);
            end
            send_text(kw);
            if (n == 3) begin
                send_char(rand_alnum(), 1'b0);
            end
        end else if (r < 35) begin
            send_char(rand_alpha(), 1'b0);
            n = $urandom_range(0, 10);
            repeat (n) send_char(rand_alnum(), 1'b0);
        end else if (r < 45) begin
            n = $urandom_range(1, 8);
            repeat (n) send_char(8'("0" + $urandom_range(0, 9)), 1'b0);
        end else if (r < 58) begin
            send_char(CH_QUOTE, 1'b0);
            n = $urandom_range(0, 12);
            repeat (n) send_char(rand_not_quote(), 1'b0);
            if ($urandom_range(0, 9) < 8) begin
                send_char(CH_QUOTE, 1'b0);
            end
        end else if (r < 72) begin
            case ($urandom_range(0, 3))
                0:       send_char(CH_LPAREN, 1'b0);
                1:       send_char(CH_RPAREN, 1'b0);
                2:       send_char(CH_LBRACE, 1'b0);
                default: send_char(CH_RBRACE, 1'b0);
            endcase
        end else if (r < 82) begin
            n = $urandom_range(1, 3);
            repeat (n) send_char(rand_space(), 1'b0);
        end else if (r < 92) begin
            send_char(8'($urandom_range(0, 255)), 1'b0);
        end else begin
            send_end();
        end
        if ($urandom_range(0, 1) == 1) begin
            send_char(rand_space(), 1'b0);
        end
    endtask

    // Tokens around the length cap: a word that starts like a keyword,
    // a digit run and a quoted string.
    task automatic send_long(input int which);
        int n;
        n = $urandom_range(MAX_TOKEN - 2, MAX_TOKEN + 30);
        case (which)
            0: begin
                send_text("main");
                repeat (n - 4) send_char(rand_alnum(), 1'b0);
            end
            1: begin
                repeat (n) send_char(8'("0" + $urandom_range(0, 9)), 1'b0);
            end
            default: begin
                send_char(CH_QUOTE, 1'b0);
                repeat (n) send_char(rand_not_quote(), 1'b0);
                send_char(CH_QUOTE, 1'b0);
            end
        endcase
        send_char(rand_space(), 1'b0);
    endtask

    initial begin : receiver
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge clk);
            if (hold_go) begin
                hold_go = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            if (stall_left > 0) begin
                out_ready <= 1'b0;
                stall_left--;
            end else begin
                out_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0) begin
                    stall_left = pick_gap();
                end
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && o_out_valid && out_ready) begin
            sb.check_token(t_result'({o_kind, o_is_char, o_value_char, o_token_length, o_last}));
        end
    end

    always @(posedge clk) begin
        if ((in_valid && o_in_ready) || (o_out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("token_lexer test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        int goal;
        int longs_done;
        longs_done = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_end();
        send_text("main(print{return})");
        send_char(8'h0B, 1'b0);
        send_char(CH_QUOTE, 1'b0);
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b0);
        send_char(CH_QUOTE, 1'b0);
        send_char(8'h80, 1'b0);
        send_text("7x");
        send_end();
        send_end();

        hold_go = 1'b1;
        goal = sent_chars + RANDOM_ITEMS;
        while (sent_chars < goal) begin
            steady = ((sent_chars / 150) % 4 == 3);
            if (longs_done < 3 && sent_chars > goal - RANDOM_ITEMS + 300 * (longs_done + 1)) begin
                send_long(longs_done);
                longs_done++;
            end
            send_lexeme();
        end
        send_end();
        in_valid <= 1'b0;

        while (sb.expected_tokens.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.expected_tokens.size() == 0) begin
            $display("token_lexer test passed");
        end else begin
            $display("token_lexer test failed");
        end
        $finish;
    end

endmodule
